// File: sv/cppd_pkg.sv
// cppd_pkg: types, constants and fixed-point helpers for the projection unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cppd_pkg;

  localparam int DIV_LAT = 34;
  localparam int Q_DEPTH = 2;
  localparam int Q_PW = $clog2(Q_DEPTH);
  localparam int PV_LEN = 2 * DIV_LAT + 12;

  localparam logic [2:0] REG_FOCAL = 3'd0;
  localparam logic [2:0] REG_PP    = 3'd1;
  localparam logic [2:0] REG_K12   = 3'd2;
  localparam logic [2:0] REG_P12   = 3'd3;
  localparam logic [2:0] REG_K34   = 3'd4;
  localparam logic [2:0] REG_K56   = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_RADIAL = 2'd1;

  localparam logic signed [31:0] Z_MIN_RAW = 32'sd3276;
  localparam logic signed [63:0] ONE_Q24 = 64'sd16777216;
  localparam logic signed [63:0] HALF_Q8 = 64'sd128;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] S16_MAX = 64'sd32767;
  localparam logic signed [63:0] S16_MIN = -64'sd32768;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               enable;
  } in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic signed [15:0] anchor_col;
    logic signed [15:0] anchor_row;
    logic [30:0]        depth_out;
    logic               saturated;
  } out_t;

  typedef struct packed {
    in_t  item;
    logic ok;
  } qitem_t;

  typedef struct packed {
    logic [31:0]        fx;
    logic [31:0]        fy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] k4;
    logic signed [31:0] k5;
    logic signed [31:0] k6;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic [1:0]         mode;
  } cfg_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } q_t;

  typedef struct packed {
    logic               sat;
    logic signed [15:0] val;
  } a_t;

  typedef struct packed {
    logic               valid;
    logic [30:0]        z;
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    logic               sb;
    logic               sr;
    logic               sf;
  } side_t;

  typedef struct packed {
    side_t              s;
    logic signed [31:0] nom;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] ptx;
    logic signed [31:0] pty;
  } long_t;

  function automatic logic signed [63:0] sx(input logic signed [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : a;
  endfunction

  function automatic q_t sat32(input logic signed [63:0] v);
    q_t r;
    if (v > S32_MAX) begin
      r.sat = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r.sat = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] mul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    return sx(a) * sx(b);
  endfunction

  function automatic q_t mulfin(input logic signed [63:0] p);
    return sat32(p >>> 24);
  endfunction

  function automatic logic signed [64:0] mulu(input logic [31:0] f,
                                              input logic signed [31:0] d);
    logic signed [64:0] ef;
    logic signed [64:0] ed;
    ef = $signed({33'b0, f});
    ed = $signed({{33{d[31]}}, d});
    return ef * ed;
  endfunction

  function automatic q_t to_pixel(input logic signed [64:0] prod,
                                  input logic signed [31:0] c);
    logic signed [64:0] sh;
    sh = prod >>> 32;
    return sat32($signed(sh[63:0]) + (sx(c) >>> 8));
  endfunction

  function automatic a_t anchor(input logic signed [31:0] p);
    logic signed [63:0] a;
    logic signed [63:0] t;
    a_t r;
    a = sx(p) + HALF_Q8;
    t = (a < 0) ? ((a + 64'sd255) >>> 8) : (a >>> 8);
    if (t > S16_MAX) begin
      r.sat = 1'b1;
      r.val = 16'sh7fff;
    end else if (t < S16_MIN) begin
      r.sat = 1'b1;
      r.val = 16'sh8000;
    end else begin
      r.sat = 1'b0;
      r.val = t[15:0];
    end
    return r;
  endfunction

endpackage

// File: sv/camera_point_projection_distort_unit.sv
// camera_point_projection_distort_unit: top level, config registers, front/queue/back.
// Depends on cppd_pkg, cppd_front, cppd_queue, cppd_back.
//
//   channel   signals                                    beat taken when
//   command   start, item, busy                          start && !busy
//   result    done, result                               done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// One point per cycle sustained while busy is low. A point passes the front stage and
// queue, two dividers (x/z and y/z, then nom/den) and the multiply and add stages
// before its result is taken.
// Synchronous active-high reset clears config (mode none) and valid/control registers.
// busy rises only if the queue fills; the back pipeline never stalls.
`timescale 1ns / 1ps
module camera_point_projection_distort_unit import cppd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  in_t         item,
  output logic        busy,
  output logic        done,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t   cfg;
  logic   push, push_ready, pop_valid, pop;
  qitem_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL: begin
          cfg.fx <= cfg_data[63:32];
          cfg.fy <= cfg_data[31:0];
        end
        REG_PP: begin
          cfg.cx <= cfg_data[63:32];
          cfg.cy <= cfg_data[31:0];
        end
        REG_K12: begin
          cfg.k1 <= cfg_data[63:32];
          cfg.k2 <= cfg_data[31:0];
        end
        REG_P12: begin
          cfg.p1 <= cfg_data[63:32];
          cfg.p2 <= cfg_data[31:0];
        end
        REG_K34: begin
          cfg.k3 <= cfg_data[63:32];
          cfg.k4 <= cfg_data[31:0];
        end
        REG_K56: begin
          cfg.k5 <= cfg_data[63:32];
          cfg.k6 <= cfg_data[31:0];
        end
        REG_MODE: begin
          cfg.mode <= cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  cppd_front u_front (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .push(push), .push_data(push_data), .push_ready(push_ready)
  );

  cppd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .push_ready(push_ready), .pop_valid(pop_valid), .pop_data(pop_data), .pop(pop)
  );

  cppd_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .pop_valid(pop_valid), .pop_data(pop_data),
    .pop(pop), .done(done), .result(result)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.valid_res |-> result.pixel_u == 0 && result.pixel_v == 0
      && result.saturated == 1'b0 && result.depth_out == 0)
    else $error("invalid result carries nonzero fields");

  a_valid_depth: assert property (@(posedge clk) disable iff (rst)
    done && result.valid_res |-> result.depth_out > 31'd3276)
    else $error("valid result with depth at or below threshold");

endmodule

// File: sv/cppd_front.sv
// cppd_front: takes commands, checks enable and depth, stages the beat for the queue.
// Depends on cppd_pkg.
`timescale 1ns / 1ps
module cppd_front import cppd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  in_t    item,
  output logic   busy,
  output logic   push,
  output qitem_t push_data,
  input  logic   push_ready
);

  logic   fv;
  qitem_t fdata;
  logic   take;

  assign busy = fv && !push_ready;
  assign take = start && !busy;
  assign push = fv;
  assign push_data = fdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (push_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fdata <= '{item: item, ok: item.enable && (item.point_z > Z_MIN_RAW)};
    end
  end

endmodule

// File: sv/cppd_queue.sv
// cppd_queue: short FIFO between the front and the back.
// Depends on cppd_pkg.
`timescale 1ns / 1ps
module cppd_queue import cppd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t push_data,
  output logic   push_ready,
  output logic   pop_valid,
  output qitem_t pop_data,
  input  logic   pop
);

  qitem_t          entries [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr;
  logic [Q_PW-1:0] rd_ptr;
  logic [Q_PW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != (Q_PW+1)'(Q_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = entries[rd_ptr];
  assign do_push = push && push_ready;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: sv/cppd_div.sv
// cppd_div: pipelined restoring divider, one quotient bit per stage, Q8.24 clipped result.
// Depends on cppd_pkg.
`timescale 1ns / 1ps
module cppd_div import cppd_pkg::*; (
  input  logic        clk,
  input  logic        num_neg,
  input  logic [55:0] num_mag,
  input  logic        den_neg,
  input  logic [31:0] den_mag,
  output q_t          res
);

  logic [31:0] rem  [33];
  logic [31:0] low  [33];
  logic [31:0] dv   [33];
  logic        neg  [33];
  logic        ovf  [33];
  logic        zero [33];

  always_ff @(posedge clk) begin
    rem[0] <= {8'b0, num_mag[55:32]};
    low[0] <= num_mag[31:0];
    dv[0] <= den_mag;
    neg[0] <= num_neg ^ den_neg;
    ovf[0] <= ({8'b0, num_mag[55:32]} >= den_mag);
    zero[0] <= (num_mag == '0);
  end

  for (genvar i = 0; i < 32; i++) begin : g_stage
    logic [32:0] t;
    logic        qb;
    assign t = {rem[i], low[i][31]};
    assign qb = (t >= {1'b0, dv[i]});
    always_ff @(posedge clk) begin
      rem[i+1] <= qb ? 32'(t - {1'b0, dv[i]}) : t[31:0];
      low[i+1] <= {low[i][30:0], qb};
      dv[i+1] <= dv[i];
      neg[i+1] <= neg[i];
      ovf[i+1] <= ovf[i];
      zero[i+1] <= zero[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ovf[32]) begin
      res.sat <= 1'b1;
      res.val <= zero[32] ? 32'sd0 : (neg[32] ? 32'sh80000000 : 32'sh7fffffff);
    end else if (!neg[32]) begin
      res.sat <= low[32][31];
      res.val <= low[32][31] ? 32'sh7fffffff : low[32];
    end else begin
      res.sat <= (low[32] > 32'h80000000);
      res.val <= (low[32] > 32'h80000000) ? 32'sh80000000 : 32'(-low[32]);
    end
  end

endmodule

// File: sv/cppd_back.sv
// cppd_back: projection pipeline: x/z and y/z, distortion, focal scale, anchor.
// Depends on cppd_pkg and cppd_div.
`timescale 1ns / 1ps
module cppd_back import cppd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   pop_valid,
  input  qitem_t pop_data,
  output logic   pop,
  output logic   done,
  output out_t   result
);

  assign pop = pop_valid;

  // x/z and y/z
  q_t          xres;
  q_t          yres;
  logic        dz_valid [DIV_LAT];
  logic [30:0] dz_z     [DIV_LAT];

  cppd_div u_div_x (
    .clk(clk), .num_neg(pop_data.item.point_x[31]),
    .num_mag({mag(pop_data.item.point_x), 24'b0}),
    .den_neg(pop_data.item.point_z[31]), .den_mag(mag(pop_data.item.point_z)),
    .res(xres)
  );
  cppd_div u_div_y (
    .clk(clk), .num_neg(pop_data.item.point_y[31]),
    .num_mag({mag(pop_data.item.point_y), 24'b0}),
    .den_neg(pop_data.item.point_z[31]), .den_mag(mag(pop_data.item.point_z)),
    .res(yres)
  );

  always_ff @(posedge clk) begin
    dz_z[0] <= pop_data.item.point_z[30:0];
    for (int i = 1; i < DIV_LAT; i++) begin
      dz_z[i] <= dz_z[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dz_valid[i] <= 1'b0;
      end
    end else begin
      dz_valid[0] <= pop_valid && pop_data.ok;
      for (int i = 1; i < DIV_LAT; i++) begin
        dz_valid[i] <= dz_valid[i-1];
      end
    end
  end

  // distortion polynomial stages
  side_t s1, s2, s3, s4, s5, s6, s7, s8;
  side_t s2_next, s3_next, s4_next, s6_next, s8_next;
  logic signed [63:0] p_xx, p_yy, p_px1, p_px2;
  logic signed [31:0] r2_2, xxc_2, yyc_2, px1_2, px2_2;
  logic signed [63:0] p_r4, p_k1, p_k4, p_t1, p_t2;
  logic signed [31:0] r2_3, tx_3, ty_3;
  logic signed [31:0] r2_4, r4_4, k1r2_4, k4r2_4, t1_4, t2_4, tx_4, ty_4;
  logic signed [63:0] p_r6, p_k2, p_k5, p_ptx, p_pty;
  logic signed [31:0] k1r2_5, k4r2_5, t1_5, t2_5;
  logic signed [31:0] r6_6, k1r2_6, k2r4_6, k4r2_6, k5r4_6, t1_6, t2_6, ptx_6, pty_6;
  logic signed [63:0] p_k3, p_k6;
  logic signed [31:0] k1r2_7, k2r4_7, k4r2_7, k5r4_7, t1_7, t2_7, ptx_7, pty_7;
  logic signed [31:0] nom_8, den_8, t1_8, t2_8, ptx_8, pty_8;

  q_t c_xx, c_yy, c_r2, c_px1, c_px2, c_tx, c_ty;
  q_t c_r4, c_k1, c_k4, c_t1, c_t2;
  q_t c_r6, c_k2, c_k5, c_ptx, c_pty;
  q_t c_k3, c_k6, c_nom, c_den;

  always_comb begin
    c_xx = mulfin(p_xx);
    c_yy = mulfin(p_yy);
    c_r2 = sat32(sx(c_xx.val) + sx(c_yy.val));
    c_px1 = mulfin(p_px1);
    c_px2 = mulfin(p_px2);
    c_tx = sat32(sx(r2_2) + (sx(xxc_2) <<< 1));
    c_ty = sat32(sx(r2_2) + (sx(yyc_2) <<< 1));
    c_r4 = mulfin(p_r4);
    c_k1 = mulfin(p_k1);
    c_k4 = mulfin(p_k4);
    c_t1 = mulfin(p_t1);
    c_t2 = mulfin(p_t2);
    c_r6 = mulfin(p_r6);
    c_k2 = mulfin(p_k2);
    c_k5 = mulfin(p_k5);
    c_ptx = mulfin(p_ptx);
    c_pty = mulfin(p_pty);
    c_k3 = mulfin(p_k3);
    c_k6 = mulfin(p_k6);
    c_nom = sat32(ONE_Q24 + sx(k1r2_7) + sx(k2r4_7) + sx(c_k3.val));
    c_den = sat32(ONE_Q24 + sx(k4r2_7) + sx(k5r4_7) + sx(c_k6.val));

    s2_next = s1;
    s2_next.sr = s1.sr | c_xx.sat | c_yy.sat | c_r2.sat;
    s2_next.sf = s1.sf | c_px1.sat | c_px2.sat;
    s3_next = s2;
    s3_next.sf = s2.sf | c_tx.sat | c_ty.sat;
    s4_next = s3;
    s4_next.sr = s3.sr | c_r4.sat | c_k1.sat;
    s4_next.sf = s3.sf | c_k4.sat | c_t1.sat | c_t2.sat;
    s6_next = s5;
    s6_next.sr = s5.sr | c_r6.sat | c_k2.sat;
    s6_next.sf = s5.sf | c_k5.sat | c_ptx.sat | c_pty.sat;
    s8_next = s7;
    s8_next.sr = s7.sr | c_k3.sat | c_nom.sat;
    s8_next.sf = s7.sf | c_k6.sat | c_den.sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
      s5 <= '0;
      s6 <= '0;
      s7 <= '0;
      s8 <= '0;
    end else begin
      s1 <= '{valid: dz_valid[DIV_LAT-1], z: dz_z[DIV_LAT-1], xn: xres.val,
              yn: yres.val, sb: xres.sat | yres.sat, sr: 1'b0, sf: 1'b0};
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s4;
      s6 <= s6_next;
      s7 <= s6;
      s8 <= s8_next;
    end

    p_xx <= mul(xres.val, xres.val);
    p_yy <= mul(yres.val, yres.val);
    p_px1 <= mul(cfg.p1, xres.val);
    p_px2 <= mul(cfg.p2, xres.val);

    r2_2 <= c_r2.val;
    xxc_2 <= c_xx.val;
    yyc_2 <= c_yy.val;
    px1_2 <= c_px1.val;
    px2_2 <= c_px2.val;

    p_r4 <= mul(r2_2, r2_2);
    p_k1 <= mul(cfg.k1, r2_2);
    p_k4 <= mul(cfg.k4, r2_2);
    p_t1 <= mul(px1_2, s2.yn);
    p_t2 <= mul(px2_2, s2.yn);
    r2_3 <= r2_2;
    tx_3 <= c_tx.val;
    ty_3 <= c_ty.val;

    r2_4 <= r2_3;
    r4_4 <= c_r4.val;
    k1r2_4 <= c_k1.val;
    k4r2_4 <= c_k4.val;
    t1_4 <= c_t1.val;
    t2_4 <= c_t2.val;
    tx_4 <= tx_3;
    ty_4 <= ty_3;

    p_r6 <= mul(r4_4, r2_4);
    p_k2 <= mul(cfg.k2, r4_4);
    p_k5 <= mul(cfg.k5, r4_4);
    p_ptx <= mul(cfg.p2, tx_4);
    p_pty <= mul(cfg.p1, ty_4);
    k1r2_5 <= k1r2_4;
    k4r2_5 <= k4r2_4;
    t1_5 <= t1_4;
    t2_5 <= t2_4;

    r6_6 <= c_r6.val;
    k1r2_6 <= k1r2_5;
    k2r4_6 <= c_k2.val;
    k4r2_6 <= k4r2_5;
    k5r4_6 <= c_k5.val;
    t1_6 <= t1_5;
    t2_6 <= t2_5;
    ptx_6 <= c_ptx.val;
    pty_6 <= c_pty.val;

    p_k3 <= mul(cfg.k3, r6_6);
    p_k6 <= mul(cfg.k6, r6_6);
    k1r2_7 <= k1r2_6;
    k2r4_7 <= k2r4_6;
    k4r2_7 <= k4r2_6;
    k5r4_7 <= k5r4_6;
    t1_7 <= t1_6;
    t2_7 <= t2_6;
    ptx_7 <= ptx_6;
    pty_7 <= pty_6;

    nom_8 <= c_nom.val;
    den_8 <= c_den.val;
    t1_8 <= t1_7;
    t2_8 <= t2_7;
    ptx_8 <= ptx_7;
    pty_8 <= pty_7;
  end

  // rational quotient nom/den
  q_t    qres;
  long_t dl [DIV_LAT];

  cppd_div u_div_q (
    .clk(clk), .num_neg(nom_8[31]), .num_mag({mag(nom_8), 24'b0}),
    .den_neg(den_8[31]), .den_mag(mag(den_8)), .res(qres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl[i] <= '0;
      end
    end else begin
      dl[0] <= '{s: s8, nom: nom_8, t1: t1_8, t2: t2_8, ptx: ptx_8, pty: pty_8};
      for (int i = 1; i < DIV_LAT; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  // distorted coordinates, pixel mapping, anchor
  long_t l1;
  logic  qsat_1;
  logic signed [63:0] p_xq, p_yq, p_xm, p_ym;
  side_t s10, s11, s12;
  side_t s10_next, s12_next;
  logic signed [31:0] xd_10, yd_10;
  logic signed [64:0] p_u, p_v;
  logic signed [31:0] u_12, v_12;
  q_t c_xq, c_yq, c_xm, c_ym, c_xf, c_yf, c_u, c_v;
  a_t a_col, a_row;
  logic sat_d;
  logic signed [31:0] xd_sel, yd_sel;

  always_comb begin
    c_xq = mulfin(p_xq);
    c_yq = mulfin(p_yq);
    c_xm = mulfin(p_xm);
    c_ym = mulfin(p_ym);
    c_xf = sat32(sx(c_xq.val) + (sx(l1.t1) <<< 1) + sx(l1.ptx));
    c_yf = sat32(sx(c_yq.val) + (sx(l1.t2) <<< 1) + sx(l1.pty));
    case (cfg.mode)
      MODE_NONE: begin
        xd_sel = l1.s.xn;
        yd_sel = l1.s.yn;
        sat_d = l1.s.sb;
      end
      MODE_RADIAL: begin
        xd_sel = c_xm.val;
        yd_sel = c_ym.val;
        sat_d = l1.s.sb | l1.s.sr | c_xm.sat | c_ym.sat;
      end
      default: begin
        xd_sel = c_xf.val;
        yd_sel = c_yf.val;
        sat_d = l1.s.sb | l1.s.sr | l1.s.sf | qsat_1 | c_xq.sat | c_yq.sat
                | c_xf.sat | c_yf.sat;
      end
    endcase
    c_u = to_pixel(p_u, cfg.cx);
    c_v = to_pixel(p_v, cfg.cy);
    a_col = anchor(u_12);
    a_row = anchor(v_12);
    s10_next = l1.s;
    s10_next.sb = sat_d;
    s12_next = s11;
    s12_next.sb = s11.sb | c_u.sat | c_v.sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= '0;
      s10 <= '0;
      s11 <= '0;
      s12 <= '0;
    end else begin
      l1 <= dl[DIV_LAT-1];
      s10 <= s10_next;
      s11 <= s10;
      s12 <= s12_next;
    end

    qsat_1 <= qres.sat;
    p_xq <= mul(dl[DIV_LAT-1].s.xn, qres.val);
    p_yq <= mul(dl[DIV_LAT-1].s.yn, qres.val);
    p_xm <= mul(dl[DIV_LAT-1].s.xn, dl[DIV_LAT-1].nom);
    p_ym <= mul(dl[DIV_LAT-1].s.yn, dl[DIV_LAT-1].nom);

    xd_10 <= xd_sel;
    yd_10 <= yd_sel;

    p_u <= mulu(cfg.fx, xd_10);
    p_v <= mulu(cfg.fy, yd_10);

    u_12 <= c_u.val;
    v_12 <= c_v.val;

    if (s12.valid) begin
      result <= '{valid_res: 1'b1, pixel_u: u_12, pixel_v: v_12,
                  anchor_col: a_col.val, anchor_row: a_row.val, depth_out: s12.z,
                  saturated: s12.sb | a_col.sat | a_row.sat};
    end else begin
      result <= '0;
    end
  end

  // every popped beat comes out, invalid ones with zeroed fields
  logic pv [PV_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PV_LEN; i++) begin
        pv[i] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      pv[0] <= pop_valid;
      for (int i = 1; i < PV_LEN; i++) begin
        pv[i] <= pv[i-1];
      end
      done <= pv[PV_LEN-1];
    end
  end

endmodule
